// ===== hdl/wsb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsb_pkg
// Shared widths, codes and controller/datapath interface types for the
// wasted space bound unit.
// ----------------------------------------------------------------------------
package wsb_pkg;

   localparam int SIDE_W  = 7;
   localparam int BIN_W   = 13;
   localparam int ELEM_W  = 24;
   localparam int WASTE_W = 13;
   localparam int BOX_W   = 2 * SIDE_W;
   localparam int OP_W    = 2;

   localparam logic [BIN_W-1:0]   BIN_MAX   = {BIN_W{1'b1}};
   localparam logic [ELEM_W-1:0]  ELEM_MAX  = {ELEM_W{1'b1}};
   localparam logic [WASTE_W-1:0] WASTE_MAX = {WASTE_W{1'b1}};

   localparam logic [SIDE_W-1:0] BOX_RESET = 7'd64;

   localparam logic [OP_W-1:0] OP_ADD_CELL = 2'd0;
   localparam logic [OP_W-1:0] OP_ADD_RECT = 2'd1;
   localparam logic [OP_W-1:0] OP_EVALUATE = 2'd2;

   localparam logic REG_BOX_WIDTH  = 1'b0;
   localparam logic REG_BOX_HEIGHT = 1'b1;

   typedef struct packed {
      logic add_cell;
      logic add_rect;
      logic add_wr;
      logic eval;
      logic sweep;
      logic scan_use;
      logic load_rsp;
   } wsb_cmd_type;

   typedef struct packed {
      logic sweep_last;
      logic empty;
   } wsb_status_type;

endpackage
`default_nettype wire

// ===== hdl/wsb_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsb_datapath
// Histogram memories, extents, scan accumulators and result registers.
// ----------------------------------------------------------------------------
module wsb_datapath import wsb_pkg::*; #(
   parameter int MAX_SIDE = 64
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wsb_cmd_type             cmd,
   output wsb_status_type          status,
   input  wire  [SIDE_W-1:0]       cell_run,
   input  wire  [SIDE_W-1:0]       rect_min_dim,
   input  wire  [ELEM_W-1:0]       rect_area,
   input  wire  [ELEM_W-1:0]       total_area,
   input  wire  [SIDE_W-1:0]       box_width,
   input  wire  [SIDE_W-1:0]       box_height,
   output logic [WASTE_W-1:0]      wasted_space,
   output logic                    prune
);

   localparam int DEPTH = MAX_SIDE + 1;
   localparam int AW    = $clog2(DEPTH);
   localparam int EW    = $clog2(DEPTH + 1);
   localparam int IW    = (AW > SIDE_W) ? AW : SIDE_W;
   localparam int CARW  = ELEM_W + AW;
   localparam int PW    = ELEM_W + 1;

   logic [BIN_W-1:0]  bin_mem  [DEPTH];
   logic [ELEM_W-1:0] elem_mem [DEPTH];

   logic [BIN_W-1:0]   bin_rd_ff;
   logic [ELEM_W-1:0]  elem_rd_ff;
   logic [AW-1:0]      idx_ff, idx_in;
   logic [AW-1:0]      end_ff, end_in;
   logic [EW-1:0]      limit_ff, limit_in;
   logic [EW-1:0]      bin_ext_ff, bin_ext_in;
   logic [EW-1:0]      elem_ext_ff, elem_ext_in;
   logic               add_bin_ff, add_bin_in;
   logic               add_elem_ff, add_elem_in;
   logic [AW-1:0]      add_addr_ff, add_addr_in;
   logic [ELEM_W-1:0]  area_ff, area_in;
   logic [ELEM_W-1:0]  total_ff, total_in;
   logic [BOX_W-1:0]   box_ff, box_in;
   logic               p1_use_ff, p1_use_in;
   logic [CARW-1:0]    carry_ff, carry_in;
   logic [BIN_W-1:0]   slack_ff, slack_in;
   logic [WASTE_W-1:0] waste_ff, waste_in;
   logic [WASTE_W-1:0] rsp_waste_ff, rsp_waste_in;
   logic               rsp_prune_ff, rsp_prune_in;

   logic              cell_ok, rect_ok;
   logic [AW-1:0]     cell_addr, rect_addr;
   logic [AW-1:0]     bin_ra, elem_ra, wr_addr;
   logic              bin_we, elem_we;
   logic [BIN_W-1:0]  bin_wd, bin_inc;
   logic [ELEM_W-1:0] elem_wd, elem_inc;
   logic [ELEM_W:0]   elem_sum;
   logic [EW-1:0]     cell_ext, rect_ext, max_ext, min_ext;
   logic [CARW-1:0]   need, cap_w;
   logic              fits;
   logic [WASTE_W:0]  waste_sum;
   logic [PW-1:0]     prune_sum;

   assign cell_ok   = IW'(cell_run) <= IW'(MAX_SIDE);
   assign rect_ok   = IW'(rect_min_dim) <= IW'(MAX_SIDE);
   assign cell_addr = AW'(cell_run);
   assign rect_addr = AW'(rect_min_dim);
   assign cell_ext  = EW'(cell_addr) + EW'(1);
   assign rect_ext  = EW'(rect_addr) + EW'(1);
   assign max_ext   = (bin_ext_ff > elem_ext_ff) ? bin_ext_ff : elem_ext_ff;
   assign min_ext   = (bin_ext_ff < elem_ext_ff) ? bin_ext_ff : elem_ext_ff;

   assign status.empty      = (max_ext == '0);
   assign status.sweep_last = (idx_ff == end_ff);

   // memory ports
   assign bin_ra   = cmd.sweep ? idx_ff : cell_addr;
   assign elem_ra  = cmd.sweep ? idx_ff : rect_addr;
   assign wr_addr  = cmd.sweep ? idx_ff : add_addr_ff;
   assign bin_inc  = (bin_rd_ff == BIN_MAX) ? BIN_MAX : bin_rd_ff + BIN_W'(1);
   assign elem_sum = {1'b0, elem_rd_ff} + {1'b0, area_ff};
   assign elem_inc = elem_sum[ELEM_W] ? ELEM_MAX : elem_sum[ELEM_W-1:0];
   assign bin_we   = cmd.sweep || (cmd.add_wr && add_bin_ff);
   assign elem_we  = cmd.sweep || (cmd.add_wr && add_elem_ff);
   assign bin_wd   = cmd.sweep ? '0 : bin_inc;
   assign elem_wd  = cmd.sweep ? '0 : elem_inc;

   always_ff @(posedge clock) begin
      if (bin_we) begin
         bin_mem[wr_addr] <= bin_wd;
      end
      bin_rd_ff <= bin_mem[bin_ra];
   end

   always_ff @(posedge clock) begin
      if (elem_we) begin
         elem_mem[wr_addr] <= elem_wd;
      end
      elem_rd_ff <= elem_mem[elem_ra];
   end

   // scan arithmetic
   assign cap_w     = CARW'(bin_rd_ff);
   assign need      = carry_ff + CARW'(elem_rd_ff);
   assign fits      = (need <= cap_w);
   assign waste_sum = {1'b0, waste_ff} + {1'b0, slack_ff};
   assign prune_sum = PW'(waste_ff) + PW'(total_ff);

   always_comb begin
      idx_in       = idx_ff;
      end_in       = end_ff;
      limit_in     = limit_ff;
      bin_ext_in   = bin_ext_ff;
      elem_ext_in  = elem_ext_ff;
      add_bin_in   = add_bin_ff;
      add_elem_in  = add_elem_ff;
      add_addr_in  = add_addr_ff;
      area_in      = area_ff;
      total_in     = total_ff;
      box_in       = BOX_W'(box_width) * BOX_W'(box_height);
      p1_use_in    = cmd.sweep && cmd.scan_use && (idx_ff != '0)
                     && (EW'(idx_ff) < limit_ff);
      carry_in     = carry_ff;
      slack_in     = '0;
      waste_in     = (waste_sum > {1'b0, WASTE_MAX}) ? WASTE_MAX : waste_sum[WASTE_W-1:0];
      rsp_waste_in = rsp_waste_ff;
      rsp_prune_in = rsp_prune_ff;

      if (cmd.add_cell) begin
         add_bin_in  = cell_ok;
         add_elem_in = 1'b0;
         add_addr_in = cell_addr;
         if (cell_ok && (bin_ext_ff < cell_ext)) begin
            bin_ext_in = cell_ext;
         end
      end
      if (cmd.add_rect) begin
         add_bin_in  = 1'b0;
         add_elem_in = rect_ok;
         add_addr_in = rect_addr;
         area_in     = rect_area;
         if (rect_ok && (elem_ext_ff < rect_ext)) begin
            elem_ext_in = rect_ext;
         end
      end
      if (cmd.add_wr) begin
         add_bin_in  = 1'b0;
         add_elem_in = 1'b0;
      end

      if (p1_use_ff) begin
         if (fits) begin
            slack_in = bin_rd_ff - need[BIN_W-1:0];
            carry_in = '0;
         end else begin
            carry_in = need - cap_w;
         end
      end

      if (cmd.sweep) begin
         idx_in = idx_ff + AW'(1);
      end

      if (cmd.eval) begin
         idx_in      = '0;
         end_in      = AW'(max_ext - EW'(1));
         limit_in    = min_ext;
         total_in    = total_area;
         bin_ext_in  = '0;
         elem_ext_in = '0;
         carry_in    = '0;
         slack_in    = '0;
         waste_in    = '0;
      end

      if (cmd.load_rsp) begin
         rsp_waste_in = waste_ff;
         rsp_prune_in = prune_sum > PW'(box_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff      <= '0;
         end_ff      <= AW'(MAX_SIDE);
         limit_ff    <= '0;
         bin_ext_ff  <= '0;
         elem_ext_ff <= '0;
         add_bin_ff  <= 1'b0;
         add_elem_ff <= 1'b0;
         p1_use_ff   <= 1'b0;
      end else begin
         idx_ff      <= idx_in;
         end_ff      <= end_in;
         limit_ff    <= limit_in;
         bin_ext_ff  <= bin_ext_in;
         elem_ext_ff <= elem_ext_in;
         add_bin_ff  <= add_bin_in;
         add_elem_ff <= add_elem_in;
         p1_use_ff   <= p1_use_in;
      end
   end

   always_ff @(posedge clock) begin
      add_addr_ff  <= add_addr_in;
      area_ff      <= area_in;
      total_ff     <= total_in;
      box_ff       <= box_in;
      carry_ff     <= carry_in;
      slack_ff     <= slack_in;
      waste_ff     <= waste_in;
      rsp_waste_ff <= rsp_waste_in;
      rsp_prune_ff <= rsp_prune_in;
   end

   assign wasted_space = rsp_waste_ff;
   assign prune        = rsp_prune_ff;

endmodule
`default_nettype wire

// ===== hdl/wsb_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsb_ctrl
// Sequencer: request decode, add write-back, store sweep and result handoff.
// ----------------------------------------------------------------------------
module wsb_ctrl import wsb_pkg::*; (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  wire  [OP_W-1:0]      req_operation,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output wsb_cmd_type          cmd,
   input  wsb_status_type       status
);

   localparam logic [2:0] ST_INIT   = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_ADD_WR = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;
   localparam logic [2:0] ST_DRAIN1 = 3'd4;
   localparam logic [2:0] ST_DRAIN2 = 3'd5;
   localparam logic [2:0] ST_FINISH = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_take, rsp_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      unique case (state_ff)
         ST_INIT: begin
            cmd.sweep = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               case (req_operation)
                  OP_ADD_CELL: begin
                     cmd.add_cell = 1'b1;
                     state_in     = ST_ADD_WR;
                  end
                  OP_ADD_RECT: begin
                     cmd.add_rect = 1'b1;
                     state_in     = ST_ADD_WR;
                  end
                  OP_EVALUATE: begin
                     cmd.eval = 1'b1;
                     state_in = status.empty ? ST_DRAIN1 : ST_SCAN;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_ADD_WR: begin
            cmd.add_wr = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_SCAN: begin
            cmd.sweep    = 1'b1;
            cmd.scan_use = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_DRAIN1;
            end
         end
         ST_DRAIN1: begin
            state_in = ST_DRAIN2;
         end
         ST_DRAIN2: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== hdl/wasted_space_bound_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wasted_space_bound_unit
// Wasted space pruning bound: bin and element histograms, evaluate scan.
//
//   port group   direction   contents
//   req_*        in          operation, cell_run, rect_min_dim, rect_area,
//                            total_area
//   rsp_*        out         wasted_space, prune (evaluate only)
//   csr_*        in          box_width (index 0), box_height (index 1)
//
// An add request reads its histogram entry, then writes it back (ST_ADD_WR).
// Evaluate sweeps indices 0 to max(bin extent, element extent) - 1: one
// memory read per index on the single read port, then ST_DRAIN1, ST_DRAIN2
// and ST_FINISH. After reset both memories are zeroed over indices 0 to
// MAX_SIDE with req_stall high; csr writes are taken throughout.
// A result held by rsp_stall does not block add requests.
// ----------------------------------------------------------------------------
module wasted_space_bound_unit import wsb_pkg::*; #(
   parameter int MAX_SIDE = 64
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  wire  [OP_W-1:0]      req_operation,
   input  wire  [SIDE_W-1:0]    req_cell_run,
   input  wire  [SIDE_W-1:0]    req_rect_min_dim,
   input  wire  [ELEM_W-1:0]    req_rect_area,
   input  wire  [ELEM_W-1:0]    req_total_area,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output logic [WASTE_W-1:0]   rsp_wasted_space,
   output logic                 rsp_prune,
   input  wire                  csr_write_enable,
   input  wire                  csr_index,
   input  wire  [SIDE_W-1:0]    csr_write_data
);

   logic [SIDE_W-1:0] box_width_ff, box_width_in;
   logic [SIDE_W-1:0] box_height_ff, box_height_in;
   wsb_cmd_type       cmd;
   wsb_status_type    status;

   always_comb begin
      box_width_in  = box_width_ff;
      box_height_in = box_height_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_BOX_WIDTH:  box_width_in  = csr_write_data;
            REG_BOX_HEIGHT: box_height_in = csr_write_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_width_ff  <= BOX_RESET;
         box_height_ff <= BOX_RESET;
      end else begin
         box_width_ff  <= box_width_in;
         box_height_ff <= box_height_in;
      end
   end

   wsb_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .cmd           (cmd),
      .status        (status)
   );

   wsb_datapath #(
      .MAX_SIDE (MAX_SIDE)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .cell_run     (req_cell_run),
      .rect_min_dim (req_rect_min_dim),
      .rect_area    (req_rect_area),
      .total_area   (req_total_area),
      .box_width    (box_width_ff),
      .box_height   (box_height_ff),
      .wasted_space (rsp_wasted_space),
      .prune        (rsp_prune)
   );

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for wasted_space_bound_unit. Cell and rectangle
// requests fill the two histograms and evaluate requests scan them. An
// in-bench predictor follows every accepted request and queues the bound
// that each evaluate should return. Directed cases cover store edges,
// saturation and box settings. Random add/evaluate sequences and noise
// follow, with random gaps and back-pressure.
// ----------------------------------------------------------------------------
module testbench import wsb_pkg::*;;

   localparam int SIDE_MAX      = 64;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = SIDE_MAX + 40;
   localparam int RANDOM_ITEMS  = 520;
   localparam int MIN_BOUNDS    = 40;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [OP_W-1:0]   op;
      logic [SIDE_W-1:0] run;
      logic [SIDE_W-1:0] dim;
      logic [ELEM_W-1:0] area;
      logic [ELEM_W-1:0] total;
   } request_type;

   typedef struct {
      logic [WASTE_W-1:0] wasted;
      logic               prune;
   } bound_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [OP_W-1:0]     req_operation;
   logic [SIDE_W-1:0]   req_cell_run;
   logic [SIDE_W-1:0]   req_rect_min_dim;
   logic [ELEM_W-1:0]   req_rect_area;
   logic [ELEM_W-1:0]   req_total_area;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [WASTE_W-1:0]  rsp_wasted_space;
   logic                rsp_prune;
   logic                csr_write_enable;
   logic                csr_index;
   logic [SIDE_W-1:0]   csr_write_data;

   // predictor state
   logic [BIN_W-1:0]    bin_count [0:SIDE_MAX];
   logic [ELEM_W-1:0]   elem_sum [0:SIDE_MAX];
   int unsigned         bin_extent;
   int unsigned         elem_extent;
   logic [SIDE_W-1:0]   box_w;
   logic [SIDE_W-1:0]   box_h;

   bound_type           bound_q [$];
   int                  errors;
   int                  useful_items;
   int                  evaluations;
   bit                  idling;

   wasted_space_bound_unit #(.MAX_SIDE(SIDE_MAX)) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_cell_run     (req_cell_run),
      .req_rect_min_dim (req_rect_min_dim),
      .req_rect_area    (req_rect_area),
      .req_total_area   (req_total_area),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_wasted_space (rsp_wasted_space),
      .rsp_prune        (rsp_prune),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("[wasted_space_bound_unit] ERROR");
      $finish;
   end

   task automatic report_error(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
   endtask

   function automatic int gap_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 65) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int box_cells();
      return box_w * box_h;
   endfunction

   function automatic void clear_histograms();
      foreach (bin_count[i]) begin
         bin_count[i] = '0;
         elem_sum[i]  = '0;
      end
      bin_extent  = 0;
      elem_extent = 0;
   endfunction

   function automatic void predict_request(request_type r);
      bound_type         b;
      longint unsigned   waste;
      longint unsigned   carry;
      longint unsigned   need;
      longint unsigned   sum;
      longint unsigned   cells;
      int unsigned       span;
      case (r.op)
         OP_ADD_CELL: begin
            if (r.run <= SIDE_MAX) begin
               if (bin_count[r.run] != BIN_MAX) bin_count[r.run]++;
               if (bin_extent < r.run + 1) bin_extent = r.run + 1;
            end
         end
         OP_ADD_RECT: begin
            if (r.dim <= SIDE_MAX) begin
               sum = elem_sum[r.dim] + r.area;
               elem_sum[r.dim] = (sum > ELEM_MAX) ? ELEM_MAX : sum[ELEM_W-1:0];
               if (elem_extent < r.dim + 1) elem_extent = r.dim + 1;
            end
         end
         OP_EVALUATE: begin
            span  = (bin_extent < elem_extent) ? bin_extent : elem_extent;
            waste = 0;
            carry = 0;
            for (int i = 1; i < span; i++) begin
               need = elem_sum[i] + carry;
               if (bin_count[i] >= need) begin
                  waste = waste + (bin_count[i] - need);
                  if (waste > WASTE_MAX) waste = WASTE_MAX;
                  carry = 0;
               end else begin
                  carry = need - bin_count[i];
               end
            end
            cells    = box_w * box_h;
            b.wasted = waste[WASTE_W-1:0];
            b.prune  = (waste + r.total) > cells;
            bound_q.push_back(b);
            evaluations++;
            clear_histograms();
         end
         default: ;
      endcase
   endfunction

   // request channel
   task automatic send_request(request_type r);
      int gap;
      bit taken;
      bit useful;
      gap = idling ? gap_len() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= r.op;
      req_cell_run     <= r.run;
      req_rect_min_dim <= r.dim;
      req_rect_area    <= r.area;
      req_total_area   <= r.total;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      predict_request(r);
      case (r.op)
         OP_ADD_CELL: useful = (r.run <= SIDE_MAX);
         OP_ADD_RECT: useful = (r.dim <= SIDE_MAX);
         OP_EVALUATE: useful = 1'b1;
         default:     useful = 1'b0;
      endcase
      if (useful) useful_items++;
   endtask

   task automatic add_cell(int run);
      request_type r;
      r.op    = OP_ADD_CELL;
      r.run   = SIDE_W'(run);
      r.dim   = SIDE_W'($urandom);
      r.area  = ELEM_W'($urandom);
      r.total = ELEM_W'($urandom);
      send_request(r);
   endtask

   task automatic add_rect(int dim, logic [ELEM_W-1:0] area);
      request_type r;
      r.op    = OP_ADD_RECT;
      r.run   = SIDE_W'($urandom);
      r.dim   = SIDE_W'(dim);
      r.area  = area;
      r.total = ELEM_W'($urandom);
      send_request(r);
   endtask

   task automatic evaluate(logic [ELEM_W-1:0] total);
      request_type r;
      r.op    = OP_EVALUATE;
      r.run   = SIDE_W'($urandom);
      r.dim   = SIDE_W'($urandom);
      r.area  = ELEM_W'($urandom);
      r.total = total;
      send_request(r);
   endtask

   task automatic send_noise();
      request_type r;
      r.op    = OP_W'($urandom_range(0, 3));
      r.run   = SIDE_W'($urandom);
      r.dim   = SIDE_W'($urandom);
      r.area  = ELEM_W'($urandom);
      r.total = ELEM_W'($urandom);
      send_request(r);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (bound_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_box(logic idx, logic [SIDE_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      if (idx == REG_BOX_WIDTH) begin
         box_w = value;
      end else begin
         box_h = value;
      end
   endtask

   // result channel
   initial begin : result_backpressure
      int hold;
      rsp_stall = 1'b0;
      forever begin
         repeat ($urandom_range(1, 12)) @(posedge clock);
         hold = idling ? gap_len() : 0;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : check_results
      bound_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (bound_q.size() == 0) begin
            report_error($sformatf("unexpected result waste %0d prune %0b",
                                   rsp_wasted_space, rsp_prune));
         end else begin
            want = bound_q.pop_front();
            if (rsp_wasted_space !== want.wasted)
               report_error($sformatf("wasted_space got %0d expected %0d",
                                      rsp_wasted_space, want.wasted));
            if (rsp_prune !== want.prune)
               report_error($sformatf("prune got %0b expected %0b (waste %0d)",
                                      rsp_prune, want.prune, want.wasted));
         end
      end
   end

   // tests
   task automatic test_empty_evaluate();
      evaluate('0);
      evaluate(ELEM_MAX);
      evaluate(24'd4096);
   endtask

   task automatic test_histogram_edges();
      repeat (3) add_cell(1);
      add_cell(2);
      repeat (2) add_cell(4);
      add_cell(0);
      add_cell(SIDE_MAX);
      add_cell(SIDE_MAX + 1);
      add_cell(127);
      add_rect(1, 24'd5);
      add_rect(2, 24'd0);
      add_rect(3, 24'd1);
      add_rect(0, 24'd7);
      add_rect(SIDE_MAX, ELEM_MAX);
      add_rect(SIDE_MAX, ELEM_MAX);
      add_rect(127, ELEM_MAX);
      send_noise();
      evaluate(24'd4000);
   endtask

   task automatic test_unused_operation();
      request_type r;
      add_cell(2);
      r.op    = OP_UNUSED;
      r.run   = 7'd3;
      r.dim   = 7'd3;
      r.area  = 24'd1;
      r.total = ELEM_MAX;
      send_request(r);
      add_rect(3, 24'd0);
      evaluate(24'd0);
   endtask

   task automatic test_prune_boundary();
      for (int k = 0; k < 2; k++) begin
         repeat (4) add_cell(3);
         add_rect(5, 24'd0);
         evaluate(ELEM_W'(24'd4092 + k));
      end
   endtask

   task automatic test_box_extremes();
      logic [SIDE_W-1:0] widths  [4];
      logic [SIDE_W-1:0] heights [4];
      widths  = '{7'd0, 7'd1, 7'd127, 7'd64};
      heights = '{7'd64, 7'd1, 7'd127, 7'd0};
      for (int k = 0; k < 4; k++) begin
         wait_for_results();
         write_box(REG_BOX_WIDTH, widths[k]);
         write_box(REG_BOX_HEIGHT, heights[k]);
         evaluate(24'd0);
         evaluate(24'd1);
         evaluate(ELEM_W'(box_cells()));
         evaluate(ELEM_W'(box_cells() + 1));
      end
   endtask

   task automatic test_random_sequences();
      logic [SIDE_W-1:0] corners [4];
      int start_items;
      int start_bounds;
      int phase_start;
      int phase;
      int reach;
      int len;
      corners      = '{7'd0, 7'd1, 7'd64, 7'd127};
      start_items  = useful_items;
      start_bounds = evaluations;
      phase_start  = useful_items;
      phase        = 0;
      while (useful_items - start_items < RANDOM_ITEMS ||
             evaluations - start_bounds < MIN_BOUNDS) begin
         if (useful_items - phase_start >= 100 || phase == 0) begin
            wait_for_results();
            if (phase == 0) begin
               write_box(REG_BOX_WIDTH, 7'd64);
               write_box(REG_BOX_HEIGHT, 7'd64);
            end else if ($urandom_range(0, 2) == 0) begin
               write_box(REG_BOX_WIDTH, corners[$urandom_range(0, 3)]);
               write_box(REG_BOX_HEIGHT, corners[$urandom_range(0, 3)]);
            end else begin
               write_box(REG_BOX_WIDTH, SIDE_W'($urandom_range(1, SIDE_MAX)));
               write_box(REG_BOX_HEIGHT, SIDE_W'($urandom_range(1, SIDE_MAX)));
            end
            idling      = (phase % 4 != 3);
            phase_start = useful_items;
            phase++;
         end
         if ($urandom_range(0, 99) < 85) begin
            reach = ($urandom_range(0, 3) == 0) ? $urandom_range(1, SIDE_MAX)
                                                : $urandom_range(1, 8);
            len   = $urandom_range(1, 30);
            repeat (len) begin
               if ($urandom_range(0, 99) < 60)
                  add_cell($urandom_range(0, reach));
               else
                  add_rect($urandom_range(0, reach),
                           ELEM_W'(($urandom_range(0, 9) == 0) ? $urandom
                                                               : $urandom_range(0, 3)));
            end
            case ($urandom_range(0, 3))
               0:       evaluate(ELEM_W'($urandom));
               1:       evaluate(ELEM_W'(box_cells() - $urandom_range(0, 20)));
               default: evaluate(ELEM_W'($urandom_range(0, box_cells() + 64)));
            endcase
         end else begin
            repeat ($urandom_range(1, 4)) send_noise();
         end
         if ($urandom_range(0, 9) == 0) wait_for_results();
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_operation    = OP_ADD_CELL;
      req_cell_run     = '0;
      req_rect_min_dim = '0;
      req_rect_area    = '0;
      req_total_area   = '0;
      csr_write_enable = 1'b0;
      csr_index        = REG_BOX_WIDTH;
      csr_write_data   = '0;
      errors           = 0;
      useful_items     = 0;
      evaluations      = 0;
      idling           = 1'b1;
      box_w            = BOX_RESET;
      box_h            = BOX_RESET;
      clear_histograms();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_empty_evaluate();
      test_histogram_edges();
      test_unused_operation();
      test_prune_boundary();
      test_box_extremes();
      test_random_sequences();

      wait_for_results();
      if (errors == 0 && bound_q.size() == 0) begin
         $display("[wasted_space_bound_unit] OK");
      end else begin
         $display("[wasted_space_bound_unit] ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/wsb_pkg.sv
hdl/wsb_datapath.sv
hdl/wsb_ctrl.sv
hdl/wasted_space_bound_unit.sv
dv/testbench.sv
